FILE: hw/rtl/tdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdt_pkg: shared types and constants of the tile dependency tracker
// Table geometry, item kinds, opcodes, error codes and the byte-size helper.
// ----------------------------------------------------------------------------
package tdt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int MAX_RECORDS   = 256;
   localparam int MAX_DEPS      = 3;

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int SCAN_W  = IDX_W + 1;
   localparam int RC_W    = $clog2(MAX_RECORDS + 1);
   localparam int SEQ_W   = 8;
   localparam int OP_W    = 5;
   localparam int DT_W    = 4;
   localparam int ADDR_W  = 64;
   localparam int CNT_W   = 32;
   localparam int EXT_W   = 16;
   localparam int BYTES_W = 40;
   localparam int PROD_W  = 48;
   localparam int WORK_W  = 24;

   localparam logic [WORK_W-1:0] WORK_CAP = {WORK_W{1'b1}};

   // Opcodes with special handling
   localparam logic [OP_W-1:0] OP_ASSIGN     = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD       = 5'd1;
   localparam logic [OP_W-1:0] OP_MATMUL     = 5'd3;
   localparam logic [OP_W-1:0] OP_MATMUL_ACC = 5'd4;
   localparam logic [OP_W-1:0] OP_STORE      = 5'd5;
   localparam logic [OP_W-1:0] OP_COLMAX     = 5'd8;
   localparam logic [OP_W-1:0] OP_COLSUM     = 5'd14;
   localparam logic [OP_W-1:0] OP_EXPANDS    = 5'd19;

   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_INPUT  = 2'd1,
      KIND_OUTPUT = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_DEPS       = 3'd1,
      ERR_WORK_CAP   = 3'd2,
      ERR_SHAPE      = 3'd3,
      ERR_RECORDS    = 3'd4,
      ERR_TABLE_FULL = 3'd5
   } err_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_MUL1,
      S_MUL2,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [DT_W-1:0]   dtype;
      logic [SEQ_W-1:0]  writer;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic             set_valid;
      logic [IDX_W-1:0] idx;
      entry_type        entry;
   } tbl_wr_type;

   // Bytes of a tile: ceil(count * bits / 8), element sizes are powers of two
   function automatic logic [BYTES_W-1:0] tile_bytes(input logic [CNT_W-1:0] count,
                                                     input logic [DT_W-1:0] dt);
      logic [BYTES_W-1:0] c;
      logic [BYTES_W-1:0] res;
      c = BYTES_W'(count);
      if (dt <= 4'd2)       res = c << 3;
      else if (dt <= 4'd5)  res = c << 2;
      else if (dt <= 4'd9)  res = c << 1;
      else if (dt <= 4'd12) res = c;
      else if (dt <= 4'd14) res = (c + BYTES_W'(1)) >> 1;
      else                  res = c;
      return res;
   endfunction

endpackage

FILE: hw/rtl/tdt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdt_if: request and response channels of the tile dependency tracker
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tdt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [4:0]  opcode;
   logic [3:0]  dtype_code;
   logic [63:0] tile_address;
   logic [31:0] element_count;
   logic        rank_two_or_more;
   logic [15:0] row_extent;
   logic [15:0] col_extent;

   modport source (output valid, req_type, opcode, dtype_code, tile_address,
                   element_count, rank_two_or_more, row_extent, col_extent,
                   input ready);
   modport sink (input valid, req_type, opcode, dtype_code, tile_address,
                 element_count, rank_two_or_more, row_extent, col_extent,
                 output ready);
endinterface

interface tdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  sequence_res;
   logic [4:0]  op_out;
   logic [7:0]  dep_first;
   logic [7:0]  dep_second;
   logic [7:0]  dep_third;
   logic [2:0]  dep_mask;
   logic [23:0] work_amount;
   logic [2:0]  error_code;

   modport source (output valid, sequence_res, op_out, dep_first, dep_second,
                   dep_third, dep_mask, work_amount, error_code,
                   input ready);
   modport sink (input valid, sequence_res, op_out, dep_first, dep_second,
                 dep_third, dep_mask, work_amount, error_code,
                 output ready);
endinterface

FILE: hw/rtl/tile_dependency_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_dependency_tracker: last-writer dependency scoreboard for tile records
// A record arrives as words on req_ch: start, input tiles, output tiles, end.
// Inputs look up their producer in the table; outputs become last writers.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one word per item; ready is high only while the block is
//    idle. rsp_ch carries one result per record end word.
//  - Start words and tiles that need no table access leave the block idle.
//  - An input tile that is looked up, or an output tile that updates the
//    table, is accepted in the idle state, then scanned: each entry is read
//    through the single read port and compared once its registered read
//    data returns. An apply step then updates the dependencies or the table.
//  - An end word goes through the multiply steps S_MUL1 and S_MUL2 for the
//    matmul workload, then S_EMIT loads the result register. The block is
//    then idle and ready again for the next word.
//  - The result sits in an output register; if rsp_ch stalls, a following
//    end word waits in the load cycle until the register frees up.
//  - Reset (synchronous, active high) clears all valid bits of the table,
//    the record counter, the sticky error and the record state. There is no
//    memory clearing pass.
// ----------------------------------------------------------------------------
module tile_dependency_tracker (
   input logic      clock,
   input logic      reset,
   tdt_req_if.sink  req_ch,
   tdt_rsp_if.source rsp_ch
);
   import tdt_pkg::*;

   // Control and record state
   state_type           state_ff, state_in;
   logic [SCAN_W-1:0]   scan_ff, scan_in;
   logic                cmp_live_ff, cmp_live_in;
   logic [RC_W-1:0]     rc_ff, rc_in;
   logic [OP_W-1:0]     cur_op_ff, cur_op_in;
   logic [SEQ_W-1:0]    deps_ff [3];
   logic [SEQ_W-1:0]    deps_in [3];
   logic [2:0]          mask_ff, mask_in;
   logic [7:0]          in_seen_ff, in_seen_in;
   logic [7:0]          out_seen_ff, out_seen_in;
   logic [BYTES_W-1:0]  fib_ff, fib_in;
   logic [BYTES_W-1:0]  fob_ff, fob_in;
   logic [EXT_W-1:0]    dims_ff [3];
   logic [EXT_W-1:0]    dims_in [3];
   logic [1:0]          shape_ok_ff, shape_ok_in;
   err_type             sticky_ff, sticky_in;
   logic                hit_ff, hit_in;
   logic                free_ff, free_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [SEQ_W-1:0]    hit_writer_ff, hit_writer_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [ADDR_W-1:0]   key_addr_ff, key_addr_in;
   logic [DT_W-1:0]     key_dtype_ff, key_dtype_in;
   logic                key_out_ff, key_out_in;
   logic [31:0]         prod1_ff, prod1_in;
   logic [PROD_W-1:0]   prod2_ff, prod2_in;
   logic [SEQ_W-1:0]    o_seq_ff, o_seq_in;
   logic [OP_W-1:0]     o_op_ff, o_op_in;
   logic [SEQ_W-1:0]    o_dep_ff [3];
   logic [SEQ_W-1:0]    o_dep_in [3];
   logic [2:0]          o_mask_ff, o_mask_in;
   logic [WORK_W-1:0]   o_work_ff, o_work_in;
   err_type             o_err_ff, o_err_in;

   // Table port
   logic                tbl_rd_en;
   logic [IDX_W-1:0]    tbl_rd_idx;
   entry_type           tbl_rd_entry;
   logic                tbl_rd_valid;
   tbl_wr_type          tbl_wr;

   tdt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (tbl_rd_en),
      .rd_idx   (tbl_rd_idx),
      .rd_entry (tbl_rd_entry),
      .rd_valid (tbl_rd_valid),
      .wr       (tbl_wr)
   );

   // Dependency merge of the looked-up writer
   logic       dep_dup;
   logic [1:0] dep_count;
   always_comb begin
      dep_dup   = 1'b0;
      dep_count = 2'($countones(mask_ff));
      for (int k = 0; k < 3; k++) begin
         if (mask_ff[k] && deps_ff[k] == hit_writer_ff) dep_dup = 1'b1;
      end
   end

   // End-of-record workload and error
   logic              rc_full;
   logic              is_mm;
   logic [PROD_W-1:0] end_work_raw;
   logic [WORK_W-1:0] end_work;
   err_type           end_err;
   always_comb begin
      rc_full = (rc_ff >= RC_W'(MAX_RECORDS));
      is_mm   = (cur_op_ff == OP_MATMUL) || (cur_op_ff == OP_MATMUL_ACC);
      end_err = sticky_ff;
      if (end_err == ERR_NONE && rc_full) end_err = ERR_RECORDS;
      priority if (cur_op_ff == OP_LOAD) begin
         end_work_raw = PROD_W'(fob_ff);
      end else if (cur_op_ff == OP_STORE || cur_op_ff == OP_COLMAX ||
                   cur_op_ff == OP_COLSUM) begin
         end_work_raw = PROD_W'(fib_ff);
      end else if (is_mm) begin
         end_work_raw = prod2_ff;
      end else if (cur_op_ff == OP_ASSIGN) begin
         end_work_raw = '0;
      end else begin
         end_work_raw = (out_seen_ff == 8'd0) ? PROD_W'(fib_ff) : PROD_W'(fob_ff);
      end
      if (is_mm && shape_ok_ff != 2'b11) begin
         if (end_err == ERR_NONE) end_err = ERR_SHAPE;
         end_work = '0;
      end else if (end_work_raw > PROD_W'(WORK_CAP)) begin
         if (end_err == ERR_NONE) end_err = ERR_WORK_CAP;
         end_work = WORK_CAP;
      end else begin
         end_work = end_work_raw[WORK_W-1:0];
      end
   end

   // Next state and outputs
   logic             a_at;
   logic [IDX_W-1:0] last_idx;
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      cmp_live_in   = 1'b0;
      rc_in         = rc_ff;
      cur_op_in     = cur_op_ff;
      deps_in       = deps_ff;
      mask_in       = mask_ff;
      in_seen_in    = in_seen_ff;
      out_seen_in   = out_seen_ff;
      fib_in        = fib_ff;
      fob_in        = fob_ff;
      dims_in       = dims_ff;
      shape_ok_in   = shape_ok_ff;
      sticky_in     = sticky_ff;
      hit_in        = hit_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      cmp_idx_in    = cmp_idx_ff;
      hit_idx_in    = hit_idx_ff;
      hit_writer_in = hit_writer_ff;
      free_idx_in   = free_idx_ff;
      key_addr_in   = key_addr_ff;
      key_dtype_in  = key_dtype_ff;
      key_out_in    = key_out_ff;
      prod1_in      = prod1_ff;
      prod2_in      = prod2_ff;
      o_seq_in      = o_seq_ff;
      o_op_in       = o_op_ff;
      o_dep_in      = o_dep_ff;
      o_mask_in     = o_mask_ff;
      o_work_in     = o_work_ff;
      o_err_in      = o_err_ff;
      tbl_rd_en     = 1'b0;
      tbl_rd_idx    = scan_ff[IDX_W-1:0];
      tbl_wr        = '0;
      req_ch.ready  = 1'b0;
      a_at          = (cur_op_ff == OP_MATMUL_ACC);
      last_idx      = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               key_addr_in  = req_ch.tile_address;
               key_dtype_in = req_ch.dtype_code;
               hit_in       = 1'b0;
               free_in      = 1'b0;
               scan_in      = '0;
               unique case (kind_type'(req_ch.req_type))
                  KIND_START: begin
                     cur_op_in   = req_ch.opcode;
                     deps_in     = '{default: '0};
                     mask_in     = '0;
                     in_seen_in  = '0;
                     out_seen_in = '0;
                     fib_in      = '0;
                     fob_in      = '0;
                     dims_in     = '{default: '0};
                     shape_ok_in = '0;
                  end
                  KIND_INPUT: begin
                     // inputs after an output of the same record are dropped
                     if (out_seen_ff == 8'd0) begin
                        if (in_seen_ff == 8'd0) begin
                           fib_in = tile_bytes(req_ch.element_count, req_ch.dtype_code);
                        end
                        if (cur_op_ff == OP_MATMUL || cur_op_ff == OP_MATMUL_ACC) begin
                           if (in_seen_ff == 8'(a_at)) begin
                              dims_in[0] = req_ch.row_extent;
                              dims_in[1] = req_ch.col_extent;
                              if (req_ch.rank_two_or_more) shape_ok_in[0] = 1'b1;
                           end else if (in_seen_ff == 8'(a_at) + 8'd1) begin
                              dims_in[2] = req_ch.col_extent;
                              if (req_ch.rank_two_or_more) shape_ok_in[1] = 1'b1;
                           end
                        end
                        if (in_seen_ff != 8'hFF) in_seen_in = in_seen_ff + 8'd1;
                        if (cur_op_ff != OP_ASSIGN && cur_op_ff != OP_LOAD &&
                            cur_op_ff != OP_EXPANDS) begin
                           key_out_in = 1'b0;
                           state_in   = S_SCAN;
                        end
                     end
                  end
                  KIND_OUTPUT: begin
                     if (out_seen_ff == 8'd0) begin
                        fob_in = tile_bytes(req_ch.element_count, req_ch.dtype_code);
                     end
                     if (out_seen_ff != 8'hFF) out_seen_in = out_seen_ff + 8'd1;
                     if (cur_op_ff != OP_ASSIGN && cur_op_ff != OP_STORE && !rc_full) begin
                        key_out_in = 1'b1;
                        state_in   = S_SCAN;
                     end
                  end
                  KIND_END: begin
                     state_in = S_MUL1;
                  end
                  default: ;
               endcase
            end
         end

         // Walk the table: read entry scan, compare entry scan-1
         S_SCAN: begin
            if (scan_ff < SCAN_W'(TABLE_ENTRIES)) begin
               tbl_rd_en   = 1'b1;
               cmp_live_in = 1'b1;
               cmp_idx_in  = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + SCAN_W'(1);
            end else begin
               state_in = S_APPLY;
            end
            if (cmp_live_ff) begin
               if (tbl_rd_valid) begin
                  if (!hit_ff && tbl_rd_entry.dtype == key_dtype_ff &&
                      tbl_rd_entry.addr == key_addr_ff) begin
                     hit_in        = 1'b1;
                     hit_idx_in    = cmp_idx_ff;
                     hit_writer_in = tbl_rd_entry.writer;
                  end
               end else if (!free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
            end
         end

         S_APPLY: begin
            state_in = S_IDLE;
            if (!key_out_ff) begin
               if (hit_ff && !dep_dup) begin
                  if (32'(dep_count) >= 32'(MAX_DEPS)) begin
                     if (sticky_ff == ERR_NONE) sticky_in = ERR_DEPS;
                  end else begin
                     deps_in[dep_count] = hit_writer_ff;
                     mask_in[dep_count] = 1'b1;
                  end
               end
            end else begin
               tbl_wr.entry.addr   = key_addr_ff;
               tbl_wr.entry.dtype  = key_dtype_ff;
               tbl_wr.entry.writer = rc_ff[SEQ_W-1:0];
               if (hit_ff) begin
                  tbl_wr.en  = 1'b1;
                  tbl_wr.idx = hit_idx_ff;
               end else if (free_ff) begin
                  tbl_wr.en        = 1'b1;
                  tbl_wr.set_valid = 1'b1;
                  tbl_wr.idx       = free_idx_ff;
               end else if (sticky_ff == ERR_NONE) begin
                  sticky_in = ERR_TABLE_FULL;
               end
            end
         end

         S_MUL1: begin
            prod1_in = 32'(dims_ff[0]) * 32'(dims_ff[1]);
            state_in = S_MUL2;
         end

         S_MUL2: begin
            prod2_in = PROD_W'(prod1_ff) * PROD_W'(dims_ff[2]);
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               o_seq_in     = rc_ff[SEQ_W-1:0];
               o_op_in      = cur_op_ff;
               for (int k = 0; k < 3; k++) begin
                  o_dep_in[k] = mask_ff[k] ? deps_ff[k] : '0;
               end
               o_mask_in    = mask_ff;
               o_work_in    = end_work;
               o_err_in     = end_err;
               sticky_in    = end_err;
               if (!rc_full) rc_in = rc_ff + RC_W'(1);
               deps_in      = '{default: '0};
               mask_in      = '0;
               in_seen_in   = '0;
               out_seen_in  = '0;
               fib_in       = '0;
               fob_in       = '0;
               dims_in      = '{default: '0};
               shape_ok_in  = '0;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
      if (last_idx != '0) tbl_rd_idx = last_idx;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         cmp_live_ff  <= 1'b0;
         rc_ff        <= '0;
         cur_op_ff    <= '0;
         deps_ff      <= '{default: '0};
         mask_ff      <= '0;
         in_seen_ff   <= '0;
         out_seen_ff  <= '0;
         fib_ff       <= '0;
         fob_ff       <= '0;
         dims_ff      <= '{default: '0};
         shape_ok_ff  <= '0;
         sticky_ff    <= ERR_NONE;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         cmp_live_ff  <= cmp_live_in;
         rc_ff        <= rc_in;
         cur_op_ff    <= cur_op_in;
         deps_ff      <= deps_in;
         mask_ff      <= mask_in;
         in_seen_ff   <= in_seen_in;
         out_seen_ff  <= out_seen_in;
         fib_ff       <= fib_in;
         fob_ff       <= fob_in;
         dims_ff      <= dims_in;
         shape_ok_ff  <= shape_ok_in;
         sticky_ff    <= sticky_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_writer_ff <= hit_writer_in;
      free_idx_ff   <= free_idx_in;
      key_addr_ff   <= key_addr_in;
      key_dtype_ff  <= key_dtype_in;
      key_out_ff    <= key_out_in;
      prod1_ff      <= prod1_in;
      prod2_ff      <= prod2_in;
      o_seq_ff      <= o_seq_in;
      o_op_ff       <= o_op_in;
      o_dep_ff      <= o_dep_in;
      o_mask_ff     <= o_mask_in;
      o_work_ff     <= o_work_in;
      o_err_ff      <= o_err_in;
   end

   // Response word
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sequence_res = o_seq_ff;
   assign rsp_ch.op_out       = o_op_ff;
   assign rsp_ch.dep_first    = o_dep_ff[0];
   assign rsp_ch.dep_second   = o_dep_ff[1];
   assign rsp_ch.dep_third    = o_dep_ff[2];
   assign rsp_ch.dep_mask     = o_mask_ff;
   assign rsp_ch.work_amount  = o_work_ff;
   assign rsp_ch.error_code   = o_err_ff;

`ifndef SYNTHESIS
   // Dependencies fill in order
   a_mask_packed: assert property (@(posedge clock) disable iff (reset)
      mask_ff == 3'b000 || mask_ff == 3'b001 || mask_ff == 3'b011 || mask_ff == 3'b111)
      else $error("dependency mask has a gap");

   // The record counter saturates at the record limit
   a_rc_bound: assert property (@(posedge clock) disable iff (reset)
      rc_ff <= RC_W'(MAX_RECORDS)) else $error("record counter overflow");

   // Once set, the error code holds until reset
   a_sticky_holds: assert property (@(posedge clock) disable iff (reset)
      sticky_ff != ERR_NONE |=> sticky_ff == $past(sticky_ff))
      else $error("sticky error changed");

   // An end word always starts the workload multiply
   a_end_to_mul: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.req_type == KIND_END |=> state_ff == S_MUL1)
      else $error("end word not processed");

   // The table is only written after a completed scan
   a_write_after_scan: assert property (@(posedge clock) disable iff (reset)
      tbl_wr.en |-> $past(state_ff) == S_SCAN) else $error("table write without scan");
`endif

endmodule

FILE: hw/rtl/tdt_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdt_table: last-writer table storage
// Single-port-read, single-port-write memory of keys and writers, with one
// valid flop per entry. Read data and valid are registered.
// ----------------------------------------------------------------------------
module tdt_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [tdt_pkg::IDX_W-1:0] rd_idx,
   output tdt_pkg::entry_type        rd_entry,
   output logic                      rd_valid,
   input  tdt_pkg::tbl_wr_type       wr
);
   import tdt_pkg::*;

   entry_type                mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   entry_type                rd_entry_ff;
   logic                     rd_valid_ff;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en && wr.set_valid) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

`ifndef SYNTHESIS
   // The controller never reads and writes the table in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr.en)) else $error("table read and write overlap");
`endif

endmodule

FILE: verif/tdt_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdt_scoreboard: last-writer predictor and result checker
// Tracks the dependency table and record state from accepted request words
// and compares every response word against the oldest predicted result.
// ----------------------------------------------------------------------------
import tdt_pkg::*;

class tdt_scoreboard;

   typedef struct packed {
      logic [7:0]  seq;
      logic [4:0]  op;
      logic [7:0]  d0;
      logic [7:0]  d1;
      logic [7:0]  d2;
      logic [2:0]  mask;
      logic [23:0] work;
      logic [2:0]  err;
   } result_type;

   // last-writer table copy
   bit          slot_used [TABLE_ENTRIES];
   logic [63:0] slot_addr [TABLE_ENTRIES];
   logic [3:0]  slot_dt   [TABLE_ENTRIES];
   logic [7:0]  slot_wr   [TABLE_ENTRIES];
   int unsigned rec_count;
   logic [4:0]  cur_op;
   logic [7:0]  deps [3];
   logic [2:0]  dmask;
   int unsigned n_in, n_out;
   longint unsigned in_bytes, out_bytes;
   longint unsigned dims [3];
   logic [1:0]  shape_ok;
   logic [2:0]  sticky;
   result_type  pending [$];
   int          errors;

   function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      rec_count = 0; cur_op = '0; sticky = ERR_NONE; errors = 0;
      clear_rec();
   endfunction

   function void clear_rec();
      deps = '{8'd0, 8'd0, 8'd0};
      dmask = '0; n_in = 0; n_out = 0; in_bytes = 0; out_bytes = 0;
      dims = '{0, 0, 0};
      shape_ok = '0;
   endfunction

   function void flag(logic [2:0] code);
      if (sticky == ERR_NONE) sticky = code;
   endfunction

   function longint unsigned byte_size(logic [31:0] cnt, logic [3:0] dt);
      longint unsigned bits;
      if (dt <= 2) bits = 64;
      else if (dt <= 5) bits = 32;
      else if (dt <= 9) bits = 16;
      else if (dt <= 12) bits = 8;
      else if (dt <= 14) bits = 4;
      else bits = 8;
      return (longint'(cnt) * bits + 7) / 8;
   endfunction

   function int lookup(logic [3:0] dt, logic [63:0] addr);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (slot_used[i] && slot_dt[i] == dt && slot_addr[i] == addr) return i;
      return -1;
   endfunction

   // note one accepted request word
   function void note_word(kind_type k, logic [4:0] op, logic [3:0] dt,
                           logic [63:0] addr, logic [31:0] cnt, bit rk,
                           logic [15:0] row, logic [15:0] col);
      int e, n, a_at;
      bit dup;
      longint unsigned w;
      result_type r;
      case (k)
         KIND_START: begin
            clear_rec();
            cur_op = op;
         end
         KIND_INPUT: begin
            if (n_out != 0) return;
            if (n_in == 0) in_bytes = byte_size(cnt, dt);
            if (cur_op == OP_MATMUL || cur_op == OP_MATMUL_ACC) begin
               a_at = (cur_op == OP_MATMUL_ACC) ? 1 : 0;
               if (n_in == a_at) begin
                  dims[0] = row; dims[1] = col;
                  if (rk) shape_ok[0] = 1'b1;
               end else if (n_in == a_at + 1) begin
                  dims[2] = col;
                  if (rk) shape_ok[1] = 1'b1;
               end
            end
            if (cur_op != OP_ASSIGN && cur_op != OP_LOAD && cur_op != OP_EXPANDS) begin
               e = lookup(dt, addr);
               if (e >= 0) begin
                  n = 0; dup = 1'b0;
                  for (int j = 0; j < 3; j++)
                     if (dmask[j]) begin
                        n++;
                        if (deps[j] == slot_wr[e]) dup = 1'b1;
                     end
                  if (!dup) begin
                     if (n >= MAX_DEPS) flag(ERR_DEPS);
                     else begin
                        deps[n] = slot_wr[e];
                        dmask[n] = 1'b1;
                     end
                  end
               end
            end
            if (n_in < 255) n_in++;
         end
         KIND_OUTPUT: begin
            if (n_out == 0) out_bytes = byte_size(cnt, dt);
            if (cur_op != OP_ASSIGN && cur_op != OP_STORE && rec_count < MAX_RECORDS) begin
               e = lookup(dt, addr);
               if (e < 0) begin
                  for (int i = 0; i < TABLE_ENTRIES; i++)
                     if (!slot_used[i]) begin e = i; break; end
                  if (e < 0) flag(ERR_TABLE_FULL);
                  else begin
                     slot_used[e] = 1'b1; slot_dt[e] = dt; slot_addr[e] = addr;
                  end
               end
               if (e >= 0) slot_wr[e] = rec_count[7:0];
            end
            if (n_out < 255) n_out++;
         end
         default: begin
            if (rec_count >= MAX_RECORDS) flag(ERR_RECORDS);
            if (cur_op == OP_LOAD) w = out_bytes;
            else if (cur_op == OP_STORE || cur_op == OP_COLMAX || cur_op == OP_COLSUM)
               w = in_bytes;
            else if (cur_op == OP_MATMUL || cur_op == OP_MATMUL_ACC) begin
               if (shape_ok != 2'b11) begin flag(ERR_SHAPE); w = 0; end
               else w = dims[0] * dims[1] * dims[2];
            end else if (cur_op == OP_ASSIGN) w = 0;
            else w = (n_out == 0) ? in_bytes : out_bytes;
            if (w > 64'hFFFFFF) begin flag(ERR_WORK_CAP); w = 64'hFFFFFF; end
            r.seq = rec_count[7:0]; r.op = cur_op;
            r.d0 = dmask[0] ? deps[0] : '0;
            r.d1 = dmask[1] ? deps[1] : '0;
            r.d2 = dmask[2] ? deps[2] : '0;
            r.mask = dmask; r.work = w[23:0]; r.err = sticky;
            pending = {pending, r};
            if (rec_count < MAX_RECORDS) rec_count++;
            clear_rec();
         end
      endcase
   endfunction

   // check one accepted response word
   function void check_result(result_type got);
      result_type exp_r;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         errors++;
         return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
         $display("%0t: result mismatch expected seq=%0d op=%0d deps=%0d/%0d/%0d mask=%b work=%0d err=%0d",
                  $time, exp_r.seq, exp_r.op, exp_r.d0, exp_r.d1, exp_r.d2, exp_r.mask,
                  exp_r.work, exp_r.err);
         $display("%0t:                 actual   seq=%0d op=%0d deps=%0d/%0d/%0d mask=%b work=%0d err=%0d",
                  $time, got.seq, got.op, got.d0, got.d1, got.d2, got.mask, got.work, got.err);
         errors++;
      end
   endfunction
endclass

FILE: verif/tb_tile_dependency_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_dependency_tracker: self-checking bench for the dependency tracker
// Directed records hit extremes and every special opcode but COLMAX, then random
// records over a small address pool build dependencies, fill the table and pass
// the record limit. Both channels idle at random; a scoreboard checks results.
// ----------------------------------------------------------------------------
module tb_tile_dependency_tracker;
   import tdt_pkg::*;

   localparam int WATCHDOG = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   tdt_req_if req_ch();
   tdt_rsp_if rsp_ch();

   tile_dependency_tracker u_dut (.clock(clock), .reset(reset),
                                  .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source));

   tdt_scoreboard tracker = new();
   bit hold_rsp = 1'b0;
   int idle_cycles = 0;
   logic [63:0] addr_pool [8];

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      req_ch.valid = 1'b0; req_ch.req_type = '0; req_ch.opcode = '0;
      req_ch.dtype_code = '0; req_ch.tile_address = '0; req_ch.element_count = '0;
      req_ch.rank_two_or_more = 1'b0; req_ch.row_extent = '0; req_ch.col_extent = '0;
      rsp_ch.ready = 1'b0;
   end

   // accepted words feed the scoreboard; watchdog counts quiet cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            tracker.note_word(kind_type'(req_ch.req_type), req_ch.opcode, req_ch.dtype_code,
                              req_ch.tile_address, req_ch.element_count,
                              req_ch.rank_two_or_more, req_ch.row_extent, req_ch.col_extent);
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_result({rsp_ch.sequence_res, rsp_ch.op_out, rsp_ch.dep_first,
                                  rsp_ch.dep_second, rsp_ch.dep_third, rsp_ch.dep_mask,
                                  rsp_ch.work_amount, rsp_ch.error_code});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("tb_tile_dependency_tracker: done, errors");
            $finish;
         end
      end
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: random stalls, or a long hold while hold_rsp is set
   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         if (g > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (g - 1) @(posedge clock);
         end else rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_word(kind_type k, logic [4:0] op, logic [3:0] dt,
                            logic [63:0] addr, logic [31:0] cnt, bit rk,
                            logic [15:0] row, logic [15:0] col, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid <= 1'b1; req_ch.req_type <= k; req_ch.opcode <= op;
      req_ch.dtype_code <= dt; req_ch.tile_address <= addr;
      req_ch.element_count <= cnt; req_ch.rank_two_or_more <= rk;
      req_ch.row_extent <= row; req_ch.col_extent <= col;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_start(logic [4:0] op, bit gaps);
      send_word(KIND_START, op, 4'($urandom), {$urandom, $urandom}, $urandom,
                1'($urandom), 16'($urandom), 16'($urandom), gaps);
   endtask

   task automatic send_tile(kind_type k, logic [3:0] dt, logic [63:0] addr,
                            logic [31:0] cnt, bit rk, logic [15:0] row,
                            logic [15:0] col, bit gaps);
      send_word(k, 5'($urandom), dt, addr, cnt, rk, row, col, gaps);
   endtask

   task automatic send_end(bit gaps);
      send_word(KIND_END, 5'($urandom), 4'($urandom), {$urandom, $urandom}, $urandom,
                1'($urandom), 16'($urandom), 16'($urandom), gaps);
   endtask

   function automatic logic [4:0] pick_op();
      int p;
      p = $urandom_range(0, 9);
      case (p)
         0: return OP_ASSIGN;
         1: return OP_LOAD;
         2: return OP_MATMUL;
         3: return OP_MATMUL_ACC;
         4: return OP_STORE;
         5: return OP_COLMAX;
         6: return OP_COLSUM;
         7: return OP_EXPANDS;
         default: return 5'($urandom_range(0, 31));
      endcase
   endfunction

   // one well-formed record with random content over the address pool, or with fresh output keys
   task automatic random_record(bit gaps, bit fresh_outputs);
      int n_i, n_o;
      logic [63:0] a;
      send_start(pick_op(), gaps);
      n_i = $urandom_range(0, 4);
      n_o = $urandom_range(0, 2);
      for (int i = 0; i < n_i; i++)
         send_tile(KIND_INPUT, 4'($urandom_range(0, 1)), addr_pool[$urandom_range(0, 7)],
                   ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4096),
                   $urandom_range(0, 4) != 0,
                   16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300)),
                   16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300)),
                   gaps);
      for (int i = 0; i < n_o; i++) begin
         a = fresh_outputs ? {$urandom, $urandom} : addr_pool[$urandom_range(0, 7)];
         send_tile(KIND_OUTPUT, 4'(fresh_outputs ? $urandom : $urandom_range(0, 1)), a,
                   $urandom_range(0, 4096), 1'($urandom), 16'($urandom), 16'($urandom),
                   gaps);
      end
      send_end(gaps);
   endtask

   // one random word of any kind, for broken sequences
   task automatic noise_word();
      send_word(kind_type'($urandom_range(0, 3)), 5'($urandom), 4'($urandom),
                ($urandom_range(0, 1)) ? addr_pool[$urandom_range(0, 7)] : {$urandom, $urandom},
                $urandom, 1'($urandom), 16'($urandom), 16'($urandom), 1'b1);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (TABLE_ENTRIES + 10) @(posedge clock);
   endtask

   initial begin
      int words;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < 8; i++) addr_pool[i] = {$urandom, $urandom};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: chained producers, four distinct deps, every special opcode but COLMAX
      for (int r = 0; r < 4; r++) begin
         send_start(OP_EXPANDS, 1'b0);
         send_tile(KIND_OUTPUT, 4'd15, addr_pool[r], 32'hFFFF_FFFF, 1'b1, 16'd0, 16'd0, 1'b0);
         send_end(1'b0);
      end
      send_start(OP_COLSUM, 1'b0);
      for (int r = 0; r < 4; r++)
         send_tile(KIND_INPUT, 4'd15, addr_pool[r], 32'd7, 1'b0, 16'hFFFF, 16'd0, 1'b0);
      send_end(1'b0);
      send_start(OP_MATMUL, 1'b0);
      send_tile(KIND_INPUT, 4'd14, addr_pool[0], 32'd0, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
      send_tile(KIND_INPUT, 4'd13, addr_pool[1], 32'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
      send_end(1'b0);
      send_start(OP_MATMUL_ACC, 1'b0);
      send_tile(KIND_INPUT, 4'd0, addr_pool[2], 32'd1, 1'b1, 16'd2, 16'd3, 1'b0);
      send_tile(KIND_INPUT, 4'd0, addr_pool[3], 32'd1, 1'b0, 16'd3, 16'd4, 1'b0);
      send_end(1'b0);
      send_start(OP_LOAD, 1'b0);
      send_tile(KIND_OUTPUT, 4'd12, addr_pool[0], 32'd100, 1'b0, 16'd0, 16'd0, 1'b0);
      send_tile(KIND_INPUT, 4'd0, addr_pool[0], 32'd100, 1'b0, 16'd0, 16'd0, 1'b0);
      send_end(1'b0);
      send_start(OP_STORE, 1'b0);
      send_tile(KIND_INPUT, 4'd3, addr_pool[0], 32'd9, 1'b0, 16'd0, 16'd0, 1'b0);
      send_tile(KIND_OUTPUT, 4'd3, addr_pool[5], 32'd9, 1'b0, 16'd0, 16'd0, 1'b0);
      send_end(1'b0);
      send_start(OP_ASSIGN, 1'b0);
      send_tile(KIND_OUTPUT, 4'd6, addr_pool[5], 32'd9, 1'b0, 16'd0, 16'd0, 1'b0);
      send_end(1'b0);
      send_tile(KIND_INPUT, 4'd8, addr_pool[5], 32'd5, 1'b1, 16'd1, 16'd1, 1'b0);
      send_end(1'b0);
      wait_drained();

      // long receiver hold while the sender keeps offering records
      hold_rsp = 1'b1;
      for (int r = 0; r < 8; r++) random_record(1'b0, 1'b0);

      // random: mostly well-formed records, some noise
      words = 0;
      while (words < 800) begin
         if ($urandom_range(0, 9) == 0) begin
            noise_word();
            words++;
         end else begin
            random_record(1'b1, $urandom_range(0, 3) == 0);
            words += 5;
         end
         if (words % 400 < 5 && words > 0) wait_drained();
      end
      // fill the table with fresh keys and pass the record limit
      for (int r = 0; r < 100; r++) begin
         send_start(pick_op(), 1'b1);
         send_tile(KIND_OUTPUT, 4'($urandom), {$urandom, $urandom},
                   $urandom_range(0, 4096), 1'($urandom), 16'($urandom), 16'($urandom),
                   1'b1);
         send_end(1'b1);
      end
      wait_drained();
      if (tracker.errors == 0)
         $display("tb_tile_dependency_tracker: done, clean");
      else
         $display("tb_tile_dependency_tracker: done, errors");
      $finish;
   end
endmodule

FILE: files.f
hw/rtl/tdt_pkg.sv
hw/rtl/tdt_if.sv
hw/rtl/tdt_table.sv
hw/rtl/tile_dependency_tracker.sv
verif/tdt_scoreboard.sv
verif/tb_tile_dependency_tracker.sv
